>>> design/ddsr_pkg.sv
// Shared types, constants and arithmetic helpers of the differential drive speed ramp.
`timescale 1ns / 1ps

package ddsr_pkg;

    localparam int CMD_W   = 24;  // raw wheel command width
    localparam int DT_W    = 10;  // elapsed milliseconds width
    localparam int RATE_W  = 20;  // configuration register width
    localparam int SPD_W   = 21;  // clamped wheel speed width
    localparam int ST_W    = 22;  // ramp state width
    localparam int STEP_W  = 21;  // per-tick step width
    localparam int PROD_W  = 30;  // rate * dt + bias width

    // Milliseconds per second and the bias that turns the floor into a ceiling.
    localparam logic [PROD_W-1:0] MS_PER_S  = PROD_W'(1000);
    localparam logic [PROD_W-1:0] CEIL_BIAS = PROD_W'(999);

    // Divide by 1000 as a multiply by a rounded-up reciprocal; exact for all
    // dividends below 2^PROD_W because the rounding error times the dividend
    // stays below 2^RECIP_SHIFT.
    localparam int RECIP_SHIFT = 40;
    localparam int RECIP_W     = 31;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    // Configuration register indexes.
    localparam logic [1:0] REG_MAX_SPEED  = 2'd0;
    localparam logic [1:0] REG_FWD_ACCEL  = 2'd1;
    localparam logic [1:0] REG_FWD_DECEL  = 2'd2;
    localparam logic [1:0] REG_TURN_SLEW  = 2'd3;

    localparam logic [RATE_W-1:0] MAX_SPEED_RESET = '1;

    // Everything the state update needs besides the state itself.
    typedef struct packed {
        logic                    stop;
        logic signed [SPD_W-1:0] lc;
        logic signed [SPD_W-1:0] rc;
        logic signed [SPD_W-1:0] fwd_cmd;
        logic signed [SPD_W-1:0] turn_cmd;
        logic [STEP_W-1:0]       accel_step;
        logic [STEP_W-1:0]       decel_step;
        logic [STEP_W-1:0]       turn_step;
        logic                    accel_zero;
        logic                    decel_zero;
        logic                    turn_zero;
    } ramp_req_t;

    typedef struct packed {
        logic signed [SPD_W-1:0] left_target;
        logic signed [SPD_W-1:0] right_target;
        logic                    active;
        logic signed [ST_W-1:0]  fwd_next;
        logic signed [ST_W-1:0]  turn_next;
    } ramp_res_t;

    // Clamp a signed value to +-m.
    function automatic logic signed [SPD_W-1:0] clamp_speed(
        input logic signed [CMD_W-1:0] v,
        input logic [RATE_W-1:0]       m
    );
        logic signed [CMD_W-1:0] mp;
        logic signed [CMD_W-1:0] mn;
        logic signed [CMD_W-1:0] r;
        mp = signed'({{(CMD_W-RATE_W){1'b0}}, m});
        mn = -mp;
        if (v > mp)
        begin
            r = mp;
        end
        else if (v < mn)
        begin
            r = mn;
        end
        else
        begin
            r = v;
        end
        return r[SPD_W-1:0];
    endfunction

    // Halve a signed value, rounding toward zero.
    function automatic logic signed [ST_W-1:0] half_toward_zero(
        input logic signed [ST_W:0] v
    );
        logic [ST_W:0] t;
        t = v + {{ST_W{1'b0}}, v[ST_W]};
        return signed'(t[ST_W:1]);
    endfunction

endpackage

>>> design/ddsr_step_unit.sv
// Two-stage pipelined computation of the per-tick step ceil(rate * dt / 1000), at least 1.
`timescale 1ns / 1ps

module ddsr_step_unit
(
    input  logic                          clk,
    input  logic                          en1,
    input  logic                          en2,
    input  logic [ddsr_pkg::RATE_W-1:0]   rate,
    input  logic [ddsr_pkg::DT_W-1:0]     dt,
    output logic [ddsr_pkg::STEP_W-1:0]   step,
    output logic                          rate_zero
);

    localparam int MUL_W = ddsr_pkg::PROD_W + ddsr_pkg::RECIP_W;

    logic [ddsr_pkg::PROD_W-1:0]  prod_reg;
    logic [ddsr_pkg::PROD_W-1:0]  prod_next;
    logic                         zero1_reg;
    logic [MUL_W-1:0]             quot_full;
    logic [ddsr_pkg::STEP_W-1:0]  quot;
    logic [ddsr_pkg::STEP_W-1:0]  step_reg;
    logic [ddsr_pkg::STEP_W-1:0]  step_next;
    logic                         zero2_reg;

    assign prod_next = {{(ddsr_pkg::PROD_W-ddsr_pkg::RATE_W){1'b0}}, rate}
                     * {{(ddsr_pkg::PROD_W-ddsr_pkg::DT_W){1'b0}}, dt}
                     + ddsr_pkg::CEIL_BIAS;

    assign quot_full = {{ddsr_pkg::RECIP_W{1'b0}}, prod_reg}
                     * {{ddsr_pkg::PROD_W{1'b0}}, ddsr_pkg::RECIP};
    assign quot      = quot_full[ddsr_pkg::RECIP_SHIFT +: ddsr_pkg::STEP_W];
    assign step_next = (quot == '0) ? ddsr_pkg::STEP_W'(1) : quot;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            prod_reg  <= prod_next;
            zero1_reg <= (rate == '0);
        end
        if (en2)
        begin
            step_reg  <= step_next;
            zero2_reg <= zero1_reg;
        end
    end

    assign step      = step_reg;
    assign rate_zero = zero2_reg;

endmodule

>>> design/ddsr_ramp_update.sv
// Ramp state update: slew both parts, recombine, clamp, keep direction and resync.
`timescale 1ns / 1ps

module ddsr_ramp_update
(
    input  ddsr_pkg::ramp_req_t                  req,
    input  logic signed [ddsr_pkg::ST_W-1:0]     fwd_cur,
    input  logic signed [ddsr_pkg::ST_W-1:0]     turn_cur,
    input  logic [ddsr_pkg::RATE_W-1:0]          max_speed,
    output ddsr_pkg::ramp_res_t                  res
);

    localparam int SPD_W = ddsr_pkg::SPD_W;
    localparam int ST_W  = ddsr_pkg::ST_W;
    localparam int CMD_W = ddsr_pkg::CMD_W;

    // Move cur toward tgt by at most step; a zero rate jumps to the target.
    function automatic logic signed [ST_W-1:0] approach(
        input logic signed [ST_W-1:0]        cur,
        input logic signed [SPD_W-1:0]       tgt,
        input logic [ddsr_pkg::STEP_W-1:0]   step,
        input logic                          jump
    );
        logic signed [CMD_W-1:0] diff;
        logic signed [CMD_W-1:0] s;
        logic signed [CMD_W-1:0] up;
        logic signed [CMD_W-1:0] dn;
        logic signed [ST_W-1:0]  r;
        diff = CMD_W'(tgt) - CMD_W'(cur);
        s    = signed'({{(CMD_W-ddsr_pkg::STEP_W){1'b0}}, step});
        up   = CMD_W'(cur) + s;
        dn   = CMD_W'(cur) - s;
        if (jump)
        begin
            r = ST_W'(tgt);
        end
        else if (diff > s)
        begin
            r = up[ST_W-1:0];
        end
        else if (diff < -s)
        begin
            r = dn[ST_W-1:0];
        end
        else
        begin
            r = ST_W'(tgt);
        end
        return r;
    endfunction

    // A target that points against a nonzero command is held at zero.
    function automatic logic signed [SPD_W-1:0] keep_direction(
        input logic signed [SPD_W-1:0] ramped,
        input logic signed [SPD_W-1:0] cmd
    );
        logic signed [SPD_W-1:0] r;
        r = ramped;
        if (cmd > 0 && ramped < 0)
        begin
            r = '0;
        end
        if (cmd < 0 && ramped > 0)
        begin
            r = '0;
        end
        return r;
    endfunction

    logic [ST_W-1:0]          cur_mag;
    logic [ST_W-1:0]          tgt_mag;
    logic                     use_decel;
    logic [ddsr_pkg::STEP_W-1:0] fwd_step;
    logic                     fwd_jump;
    logic signed [ST_W-1:0]   fwd_new;
    logic signed [ST_W-1:0]   turn_new;
    logic signed [CMD_W-1:0]  left_sum;
    logic signed [CMD_W-1:0]  right_sum;
    logic signed [SPD_W-1:0]  lt;
    logic signed [SPD_W-1:0]  rt;

    always_comb
    begin
        cur_mag = fwd_cur[ST_W-1] ? ST_W'(-fwd_cur) : ST_W'(fwd_cur);
        tgt_mag = req.fwd_cmd[SPD_W-1] ? ST_W'(-ST_W'(req.fwd_cmd)) : ST_W'(req.fwd_cmd);

        // Decelerate when going to zero, reversing or not growing in magnitude;
        // starting from rest always accelerates.
        if (fwd_cur == '0 && req.fwd_cmd != '0)
        begin
            use_decel = 1'b0;
        end
        else if (req.fwd_cmd == '0)
        begin
            use_decel = 1'b1;
        end
        else if (fwd_cur[ST_W-1] != req.fwd_cmd[SPD_W-1])
        begin
            use_decel = 1'b1;
        end
        else
        begin
            use_decel = !(tgt_mag > cur_mag);
        end

        fwd_step = use_decel ? req.decel_step : req.accel_step;
        fwd_jump = use_decel ? req.decel_zero : req.accel_zero;

        fwd_new  = approach(fwd_cur, req.fwd_cmd, fwd_step, fwd_jump);
        turn_new = approach(turn_cur, req.turn_cmd, req.turn_step, req.turn_zero);

        left_sum  = CMD_W'(fwd_new) + CMD_W'(turn_new);
        right_sum = CMD_W'(fwd_new) - CMD_W'(turn_new);
        lt = keep_direction(ddsr_pkg::clamp_speed(left_sum, max_speed), req.lc);
        rt = keep_direction(ddsr_pkg::clamp_speed(right_sum, max_speed), req.rc);

        if (req.stop)
        begin
            res = '0;
        end
        else
        begin
            res.left_target  = lt;
            res.right_target = rt;
            res.active       = (lt != req.lc) || (rt != req.rc);
            res.fwd_next     = ddsr_pkg::half_toward_zero((ST_W+1)'(lt) + (ST_W+1)'(rt));
            res.turn_next    = ddsr_pkg::half_toward_zero((ST_W+1)'(lt) - (ST_W+1)'(rt));
        end
    end

endmodule

>>> design/differential_drive_speed_ramp.sv
// Top level of the differential drive speed ramp: stream ports, registers and pipeline.
`timescale 1ns / 1ps

// Each request carries left and right wheel commands, the milliseconds since
// the last tick and a stop flag; each one yields exactly one result with the
// ramped left and right wheel targets and a flag that is set while either
// target still differs from its clamped command. The block takes one request
// per clock cycle while m_tready does not hold it back. A request passes
// through four registers: an input register loaded at the accepting edge, a
// stage that clamps the commands and forms the products rate times elapsed
// time, a stage that divides those by 1000 through a reciprocal multiply, and
// the final stage that slews the forward and turn state and loads the result
// register, which drives the master side. The feedback through the forward
// and turn state stays within that last stage, which is what allows a new
// request every cycle. Each stage loads whenever it is empty or its contents
// move on in the same cycle, so the block keeps taking requests while a
// result waits for the downstream side, until all four registers hold
// requests. Configuration is to be written through cfg_we/cfg_index/cfg_data
// only while no request is in flight; the block itself does not enforce this.
// After reset the clamp is at full scale and all rates are zero, which makes
// the targets follow the commands at once. A stop request clears the state.
module differential_drive_speed_ramp
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [23:0] left_command, [47:24] right_command,
                                   // [57:48] tick_ms, [63:58] zero
    input  logic        s_tuser,   // [0] stop

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [20:0] left_target, [41:21] right_target,
                                   // [47:42] zero
    output logic        m_tuser,   // [0] ramp_active

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    localparam int CMD_W  = ddsr_pkg::CMD_W;
    localparam int DT_W   = ddsr_pkg::DT_W;
    localparam int RATE_W = ddsr_pkg::RATE_W;
    localparam int SPD_W  = ddsr_pkg::SPD_W;
    localparam int ST_W   = ddsr_pkg::ST_W;
    localparam int STEP_W = ddsr_pkg::STEP_W;

    // Configuration registers.
    logic [RATE_W-1:0] max_speed_reg;
    logic [RATE_W-1:0] accel_rate_reg;
    logic [RATE_W-1:0] decel_rate_reg;
    logic [RATE_W-1:0] turn_rate_reg;

    // Stage valids and the ready chain; a stage loads when it is empty or
    // its contents move on in the same cycle.
    logic v0_reg;
    logic v1_reg;
    logic v2_reg;
    logic out_valid_reg;
    logic rdy_out;
    logic rdy2;
    logic rdy1;
    logic en1;
    logic en2;
    logic update;

    // Stage 0: the accepted request.
    logic signed [CMD_W-1:0] s0_left_reg;
    logic signed [CMD_W-1:0] s0_right_reg;
    logic [DT_W-1:0]         s0_dt_reg;
    logic                    s0_stop_reg;

    // Stage 1: clamped commands.
    logic signed [SPD_W-1:0] s1_lc_reg;
    logic signed [SPD_W-1:0] s1_rc_reg;
    logic                    s1_stop_reg;

    // Stage 2: clamped commands with their forward and turn parts.
    logic signed [SPD_W-1:0] s2_lc_reg;
    logic signed [SPD_W-1:0] s2_rc_reg;
    logic signed [SPD_W-1:0] s2_fwd_reg;
    logic signed [SPD_W-1:0] s2_turn_reg;
    logic                    s2_stop_reg;
    logic signed [ST_W-1:0]  fwd_split;
    logic signed [ST_W-1:0]  turn_split;

    // Ramp state and result register.
    logic signed [ST_W-1:0]  fwd_reg;
    logic signed [ST_W-1:0]  turn_reg;
    logic signed [SPD_W-1:0] left_out_reg;
    logic signed [SPD_W-1:0] right_out_reg;
    logic                    active_out_reg;

    logic [STEP_W-1:0] accel_step;
    logic [STEP_W-1:0] decel_step;
    logic [STEP_W-1:0] turn_step;
    logic              accel_zero;
    logic              decel_zero;
    logic              turn_zero;

    ddsr_pkg::ramp_req_t req;
    ddsr_pkg::ramp_res_t res;

    assign rdy_out  = !out_valid_reg || m_tready;
    assign rdy2     = !v2_reg || rdy_out;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = !v0_reg || rdy1;
    assign en1      = v0_reg && rdy1;
    assign en2      = v1_reg && rdy2;
    assign update   = v2_reg && rdy_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg  <= ddsr_pkg::MAX_SPEED_RESET;
            accel_rate_reg <= '0;
            decel_rate_reg <= '0;
            turn_rate_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ddsr_pkg::REG_MAX_SPEED: max_speed_reg  <= cfg_data;
                ddsr_pkg::REG_FWD_ACCEL: accel_rate_reg <= cfg_data;
                ddsr_pkg::REG_FWD_DECEL: decel_rate_reg <= cfg_data;
                ddsr_pkg::REG_TURN_SLEW: turn_rate_reg  <= cfg_data;
                default:                 max_speed_reg  <= max_speed_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= '0;
            turn_reg      <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                v0_reg <= s_tvalid;
            end
            if (rdy1)
            begin
                v1_reg <= v0_reg;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy_out)
            begin
                out_valid_reg <= v2_reg;
            end
            if (update)
            begin
                fwd_reg  <= res.fwd_next;
                turn_reg <= res.turn_next;
            end
        end
    end

    // Forward and turn parts, each halved toward zero.
    assign fwd_split  = ddsr_pkg::half_toward_zero((ST_W+1)'(s1_lc_reg) + (ST_W+1)'(s1_rc_reg));
    assign turn_split = ddsr_pkg::half_toward_zero((ST_W+1)'(s1_lc_reg) - (ST_W+1)'(s1_rc_reg));

    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            s0_left_reg  <= signed'(s_tdata[CMD_W-1:0]);
            s0_right_reg <= signed'(s_tdata[2*CMD_W-1:CMD_W]);
            s0_dt_reg    <= s_tdata[2*CMD_W +: DT_W];
            s0_stop_reg  <= s_tuser;
        end
        if (en1)
        begin
            s1_lc_reg   <= ddsr_pkg::clamp_speed(s0_left_reg, max_speed_reg);
            s1_rc_reg   <= ddsr_pkg::clamp_speed(s0_right_reg, max_speed_reg);
            s1_stop_reg <= s0_stop_reg;
        end
        if (en2)
        begin
            s2_lc_reg   <= s1_lc_reg;
            s2_rc_reg   <= s1_rc_reg;
            s2_fwd_reg  <= fwd_split[SPD_W-1:0];
            s2_turn_reg <= turn_split[SPD_W-1:0];
            s2_stop_reg <= s1_stop_reg;
        end
        if (update)
        begin
            left_out_reg   <= res.left_target;
            right_out_reg  <= res.right_target;
            active_out_reg <= res.active;
        end
    end

    ddsr_step_unit u_accel_step
    (
        .clk       (clk),
        .en1       (en1),
        .en2       (en2),
        .rate      (accel_rate_reg),
        .dt        (s0_dt_reg),
        .step      (accel_step),
        .rate_zero (accel_zero)
    );

    ddsr_step_unit u_decel_step
    (
        .clk       (clk),
        .en1       (en1),
        .en2       (en2),
        .rate      (decel_rate_reg),
        .dt        (s0_dt_reg),
        .step      (decel_step),
        .rate_zero (decel_zero)
    );

    ddsr_step_unit u_turn_step
    (
        .clk       (clk),
        .en1       (en1),
        .en2       (en2),
        .rate      (turn_rate_reg),
        .dt        (s0_dt_reg),
        .step      (turn_step),
        .rate_zero (turn_zero)
    );

    always_comb
    begin
        req.stop       = s2_stop_reg;
        req.lc         = s2_lc_reg;
        req.rc         = s2_rc_reg;
        req.fwd_cmd    = s2_fwd_reg;
        req.turn_cmd   = s2_turn_reg;
        req.accel_step = accel_step;
        req.decel_step = decel_step;
        req.turn_step  = turn_step;
        req.accel_zero = accel_zero;
        req.decel_zero = decel_zero;
        req.turn_zero  = turn_zero;
    end

    ddsr_ramp_update u_ramp_update
    (
        .req       (req),
        .fwd_cur   (fwd_reg),
        .turn_cur  (turn_reg),
        .max_speed (max_speed_reg),
        .res       (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, right_out_reg, left_out_reg};
    assign m_tuser  = active_out_reg;

    // A stop request produces an all-zero result.
    a_stop_result: assert property (@(posedge clk) disable iff (!rst_n)
        (update && s2_stop_reg) |=> (m_tdata == '0 && !m_tuser))
        else $error("stop request did not give zero targets");

    // A stop request clears both state registers.
    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (update && s2_stop_reg) |=> (fwd_reg == '0 && turn_reg == '0))
        else $error("stop request did not clear the ramp state");

    // The state only moves when a request leaves the last stage.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !update |=> ($stable(fwd_reg) && $stable(turn_reg)))
        else $error("ramp state changed without a request");

    // A waiting result does not block the input while the front stage is free.
    a_accept_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready && !v0_reg) |-> s_tready)
        else $error("input stalled behind a waiting result");

endmodule
